### src/gabor_mexican_hat_pixel_generator_assert.svh
// Assertion helpers, clocked on aclk and disabled while aresetn is low.
`ifndef GABOR_MEXICAN_HAT_PIXEL_GENERATOR_ASSERT_SVH
`define GABOR_MEXICAN_HAT_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define GMH_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gmh_pkg.sv
`default_nettype none
package gmh_pkg;

    localparam int IMAGE_SIDE = 128;

    localparam logic MODE_GABOR = 1'b0;
    localparam logic MODE_HAT   = 1'b1;

    // CORDIC
    localparam int CORDIC_N   = 16;
    localparam int CORDIC_XW  = 20;
    localparam int CORDIC_ZW  = 19;
    localparam int CORDIC_LAT = CORDIC_N + 2;
    localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 20'sd39797;
    localparam logic [16:0] TURN_SCALE = 17'd102944;
    localparam logic signed [CORDIC_ZW-1:0] CORDIC_ATAN [CORDIC_N] = '{
        19'sd51472, 19'sd30386, 19'sd16055, 19'sd8150, 19'sd4091, 19'sd2047,
        19'sd1024, 19'sd512, 19'sd256, 19'sd128, 19'sd64, 19'sd32,
        19'sd16, 19'sd8, 19'sd4, 19'sd2
    };
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [CORDIC_XW-1:0] c_val;
        logic signed [CORDIC_XW-1:0] s_val;
    } trig_t;

    // Divider: 32-bit numerator scaled by 2^16, 22 quotient bits
    localparam int DIV_NW    = 32;
    localparam int DIV_DW    = 32;
    localparam int DIV_SHIFT = 16;
    localparam int DIV_QW    = 22;
    localparam int DIV_LAT   = DIV_QW + 1;

    // exp(-a), a in Q16
    localparam int EXP_AW    = 22;
    localparam int EXP_EW    = 17;
    localparam int EXP_ORDER = 6;
    localparam int EXP_LAT   = 3 + 2 * EXP_ORDER + 1;

endpackage
`default_nettype wire

### src/gabor_mexican_hat_pixel_generator.sv
// Gabor / Mexican-hat wavelet pixel generator.
// Input stream (s_*): one item per pixel, tdata = {pixel_y, pixel_x}.
// Output stream (m_*): one item per input item, tdata = pixel_value, signed
// Q1.14 in the range -16384..16384. Pixels outside the image give 0.
// Config: APB-style, registers at byte address 4*index; write only while
// no item is in flight. pready is tied high, reads return the register.
// Pipeline: the input register and 62 stages after it, then the output buffer.
// Throughput: one item per cycle while the output buffer is not full.
// The depth is set by the 16-step angle CORDIC, the 22-stage restoring
// divider for the envelope exponents and the 6-term exp series; the carrier
// CORDIC runs beside the divider.
// Reset: synchronous active low; registers return to their defaults and the
// pipeline empties. Stall: a 2-entry output buffer keeps taking results while
// m_tready is low; once it is full the whole pipeline holds and s_tready drops.
`default_nettype none
`include "gabor_mexican_hat_pixel_generator_assert.svh"
module gabor_mexican_hat_pixel_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [6:0] pixel_x, [13:7] pixel_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] pixel_value
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import gmh_pkg::*;

    localparam logic [2:0] REG_SHAPE_MODE = 3'd0;
    localparam logic [2:0] REG_CENTER_X   = 3'd1;
    localparam logic [2:0] REG_CENTER_Y   = 3'd2;
    localparam logic [2:0] REG_SIGMA_X    = 3'd3;
    localparam logic [2:0] REG_SIGMA_Y    = 3'd4;
    localparam logic [2:0] REG_ANGLE      = 3'd5;
    localparam logic [2:0] REG_FREQUENCY  = 3'd6;
    localparam logic [2:0] REG_PHASE      = 3'd7;

    localparam int S_ROT   = 1 + CORDIC_LAT;           // trig of angle ready
    localparam int S_DIVIN = S_ROT + 3;                 // squares ready
    localparam int S_EXPIN = S_DIVIN + DIV_LAT;         // quotients ready
    localparam int S_MUL   = S_EXPIN + EXP_LAT;         // envelope ready
    localparam int PIPE_LAT = S_MUL + 2;
    localparam int CC_DLY  = DIV_LAT + EXP_LAT - CORDIC_LAT;
    localparam logic [EXP_AW-1:0] CAP_GABOR = EXP_AW'(1 << 20);
    localparam logic [EXP_AW-1:0] CAP_HAT   = EXP_AW'(1 << 21);
    localparam logic [1:0] FIFO_FULL = 2'd2;

    typedef struct packed {
        logic vld;
        logic outside;
    } pipe_ctl_t;

    function automatic logic [15:0] to_turns(input logic [15:0] v);
        logic [33:0] p;
        begin
            p = 34'(v) * 34'(17'd83443) + 34'(32768);
            return p[31:16];
        end
    endfunction

    // configuration
    logic        shape_mode_reg;
    logic [14:0] center_x_reg, center_y_reg, sigma_x_reg, sigma_y_reg, angle_reg;
    logic [15:0] frequency_reg, phase_reg;
    logic        cfg_wr;

    // derived from configuration
    logic [DIV_DW-1:0] den_a_reg, den_b_reg;
    logic [15:0]       ph_turn_reg;
    logic [14:0]       sx_eff, sy_eff;
    logic [29:0]       sx_sq, sy_sq;

    // pipeline
    logic                en_pipe;
    pipe_ctl_t           ctl_reg [PIPE_LAT];
    logic signed [16:0]  dx1_reg, dy1_reg;
    logic [15:0]         turn_a1_reg;
    logic signed [16:0]  dxl_reg [CORDIC_LAT];
    logic signed [16:0]  dyl_reg [CORDIC_LAT];
    trig_t               trig_a, trig_b;
    logic signed [36:0]  p_xc_reg, p_ys_reg, p_yc_reg, p_xs_reg;
    logic [31:0]         sq_x_reg, sq_y_reg;
    logic signed [33:0]  sq_x, sq_y;
    logic signed [37:0]  xp_sum, yp_sum;
    logic signed [17:0]  xp_reg, yp_reg;
    logic [31:0]         r2_reg;
    logic signed [35:0]  xp_sq, yp_sq;
    logic [31:0]         xp2_reg, yp2_reg, r2d_reg;
    logic signed [34:0]  fprod_reg;
    logic [15:0]         turn_b;
    logic [DIV_NW-1:0]   num_a;
    logic [DIV_QW-1:0]   quo_a, quo_b;
    logic                ovf_a, ovf_b;
    logic [EXP_AW-1:0]   cap_a, qa, qb, exp_a;
    logic [EXP_AW-1:0]   qh_reg [EXP_LAT];
    logic signed [CORDIC_XW-1:0] cc_reg [CC_DLY];
    logic [EXP_EW-1:0]   env;
    logic signed [22:0]  hat_w;
    logic signed [41:0]  prod_reg, prod_next, rnd;
    logic signed [23:0]  vsh;
    logic [15:0]         val_next;
    logic [15:0]         out_reg;
    logic                push, pop;

    // output buffer
    logic [15:0] slot_reg [FIFO_FULL];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_mode_reg <= MODE_GABOR;
            center_x_reg   <= 15'd16384;
            center_y_reg   <= 15'd16384;
            sigma_x_reg    <= 15'd2048;
            sigma_y_reg    <= 15'd2048;
            angle_reg      <= '0;
            frequency_reg  <= 16'd16384;
            phase_reg      <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_SHAPE_MODE: shape_mode_reg <= pwdata[0];
                REG_CENTER_X:   center_x_reg   <= pwdata[14:0];
                REG_CENTER_Y:   center_y_reg   <= pwdata[14:0];
                REG_SIGMA_X:    sigma_x_reg    <= pwdata[14:0];
                REG_SIGMA_Y:    sigma_y_reg    <= pwdata[14:0];
                REG_ANGLE:      angle_reg      <= pwdata[14:0];
                REG_FREQUENCY:  frequency_reg  <= pwdata[15:0];
                REG_PHASE:      phase_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SHAPE_MODE: prdata = 32'(shape_mode_reg);
            REG_CENTER_X:   prdata = 32'(center_x_reg);
            REG_CENTER_Y:   prdata = 32'(center_y_reg);
            REG_SIGMA_X:    prdata = 32'(sigma_x_reg);
            REG_SIGMA_Y:    prdata = 32'(sigma_y_reg);
            REG_ANGLE:      prdata = 32'(angle_reg);
            REG_FREQUENCY:  prdata = 32'(frequency_reg);
            REG_PHASE:      prdata = 32'(phase_reg);
            default:        prdata = '0;
        endcase
    end

    assign sx_eff = (sigma_x_reg == '0) ? 15'd1 : sigma_x_reg;
    assign sy_eff = (sigma_y_reg == '0) ? 15'd1 : sigma_y_reg;
    assign sx_sq  = 30'(sx_eff) * 30'(sx_eff);
    assign sy_sq  = 30'(sy_eff) * 30'(sy_eff);

    always_ff @(posedge aclk) begin
        den_a_reg   <= (shape_mode_reg == MODE_HAT) ? {2'b00, sx_sq} : {1'b0, sx_sq, 1'b0};
        den_b_reg   <= {1'b0, sy_sq, 1'b0};
        ph_turn_reg <= to_turns(phase_reg);
    end

    // ---------------- pipeline control ----------------
    assign en_pipe  = (cnt_reg != FIFO_FULL);
    assign s_tready = en_pipe;
    assign push     = en_pipe && ctl_reg[PIPE_LAT-1].vld;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                ctl_reg[k].vld <= 1'b0;
            end
        end else if (en_pipe) begin
            ctl_reg[0].vld     <= s_tvalid;
            ctl_reg[0].outside <= (32'(s_tdata[6:0]) >= 32'(IMAGE_SIDE)) ||
                                  (32'(s_tdata[13:7]) >= 32'(IMAGE_SIDE));
            for (int k = 1; k < PIPE_LAT; k++) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // ---------------- stage 1: offsets ----------------
    always_ff @(posedge aclk) begin
        if (en_pipe) begin
            dx1_reg     <= $signed({2'b00, s_tdata[6:0], 8'h00}) - $signed({2'b00, center_x_reg});
            dy1_reg     <= $signed({2'b00, s_tdata[13:7], 8'h00}) - $signed({2'b00, center_y_reg});
            turn_a1_reg <= to_turns({1'b0, angle_reg});
            dxl_reg[0]  <= dx1_reg;
            dyl_reg[0]  <= dy1_reg;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                dxl_reg[k] <= dxl_reg[k-1];
                dyl_reg[k] <= dyl_reg[k-1];
            end
        end
    end

    gmh_cordic u_cordic_angle (
        .aclk (aclk),
        .en   (en_pipe),
        .turn (turn_a1_reg),
        .trig (trig_a)
    );

    // ---------------- rotation and squares ----------------
    assign sq_x   = 34'(dxl_reg[CORDIC_LAT-1]) * 34'(dxl_reg[CORDIC_LAT-1]);
    assign sq_y   = 34'(dyl_reg[CORDIC_LAT-1]) * 34'(dyl_reg[CORDIC_LAT-1]);
    assign xp_sum = 38'(p_xc_reg) + 38'(p_ys_reg);
    assign yp_sum = 38'(p_yc_reg) - 38'(p_xs_reg);
    assign xp_sq  = 36'(xp_reg) * 36'(xp_reg);
    assign yp_sq  = 36'(yp_reg) * 36'(yp_reg);

    always_ff @(posedge aclk) begin
        if (en_pipe) begin
            p_xc_reg  <= 37'(dxl_reg[CORDIC_LAT-1]) * 37'(trig_a.c_val);
            p_ys_reg  <= 37'(dyl_reg[CORDIC_LAT-1]) * 37'(trig_a.s_val);
            p_yc_reg  <= 37'(dyl_reg[CORDIC_LAT-1]) * 37'(trig_a.c_val);
            p_xs_reg  <= 37'(dxl_reg[CORDIC_LAT-1]) * 37'(trig_a.s_val);
            sq_x_reg  <= sq_x[31:0];
            sq_y_reg  <= sq_y[31:0];
            xp_reg    <= xp_sum[33:16];
            yp_reg    <= yp_sum[33:16];
            r2_reg    <= sq_x_reg + sq_y_reg;
            xp2_reg   <= xp_sq[31:0];
            yp2_reg   <= yp_sq[31:0];
            r2d_reg   <= r2_reg;
            fprod_reg <= 35'($signed({1'b0, frequency_reg})) * 35'(xp_reg);
        end
    end

    // ---------------- carrier and exponent terms ----------------
    assign turn_b = fprod_reg[23:8] + ph_turn_reg;
    assign num_a  = (shape_mode_reg == MODE_HAT) ? r2d_reg : xp2_reg;

    gmh_cordic u_cordic_carrier (
        .aclk (aclk),
        .en   (en_pipe),
        .turn (turn_b),
        .trig (trig_b)
    );

    gmh_div u_div_a (
        .aclk (aclk),
        .en   (en_pipe),
        .num  (num_a),
        .den  (den_a_reg),
        .quo  (quo_a),
        .ovf  (ovf_a)
    );

    gmh_div u_div_b (
        .aclk (aclk),
        .en   (en_pipe),
        .num  (yp2_reg),
        .den  (den_b_reg),
        .quo  (quo_b),
        .ovf  (ovf_b)
    );

    assign cap_a = (shape_mode_reg == MODE_HAT) ? CAP_HAT : CAP_GABOR;
    assign qa    = (ovf_a || (EXP_AW'(quo_a) > cap_a)) ? cap_a : EXP_AW'(quo_a);
    assign qb    = (ovf_b || (EXP_AW'(quo_b) > CAP_GABOR)) ? CAP_GABOR : EXP_AW'(quo_b);
    assign exp_a = (shape_mode_reg == MODE_HAT) ? (qa >> 1) : (qa + qb);

    gmh_exp u_exp (
        .a    (exp_a),
        .aclk (aclk),
        .en   (en_pipe),
        .env  (env)
    );

    always_ff @(posedge aclk) begin
        if (en_pipe) begin
            qh_reg[0] <= qa;
            for (int k = 1; k < EXP_LAT; k++) begin
                qh_reg[k] <= qh_reg[k-1];
            end
            cc_reg[0] <= trig_b.c_val;
            for (int k = 1; k < CC_DLY; k++) begin
                cc_reg[k] <= cc_reg[k-1];
            end
        end
    end

    // ---------------- final product and rounding ----------------
    assign hat_w = 23'sd65536 - $signed({1'b0, qh_reg[EXP_LAT-1]});
    assign prod_next = (shape_mode_reg == MODE_HAT)
        ? 42'(hat_w) * 42'($signed({1'b0, env}))
        : 42'($signed({1'b0, env})) * 42'(cc_reg[CC_DLY-1]);
    assign rnd = prod_reg + 42'sd131072;
    assign vsh = rnd[41:18];

    always_comb begin
        if (ctl_reg[PIPE_LAT-2].outside) begin
            val_next = '0;
        end else if (vsh > 24'sd16384) begin
            val_next = 16'sd16384;
        end else if (vsh < -24'sd16384) begin
            val_next = -16'sd16384;
        end else begin
            val_next = vsh[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_pipe) begin
            prod_reg <= prod_next;
            out_reg  <= val_next;
        end
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= out_reg;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = slot_reg[rd_ptr_reg];

    `GMH_ASSERT_IMPLY(a_out_range, m_tvalid, ($signed(m_tdata) <= 16'sd16384) && ($signed(m_tdata) >= -16'sd16384), "pixel_value out of range")
    `GMH_ASSERT_NEXT(a_stall_hold, !en_pipe && ctl_reg[PIPE_LAT-1].vld, ctl_reg[PIPE_LAT-1].vld && $stable(out_reg), "stalled result lost")
    `GMH_ASSERT_NEXT(a_pop_count, pop && !push, cnt_reg == $past(cnt_reg) - 2'd1, "buffer count mismatch")

endmodule
`default_nettype wire

### src/gmh_cordic.sv
`default_nettype none
module gmh_cordic (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [15:0]   turn,
    output gmh_pkg::trig_t     trig
);
    import gmh_pkg::*;

    logic signed [CORDIC_XW-1:0] x_reg [CORDIC_N+1];
    logic signed [CORDIC_XW-1:0] y_reg [CORDIC_N+1];
    logic signed [CORDIC_ZW-1:0] z_reg [CORDIC_N+1];
    logic [1:0]                  q_reg [CORDIC_N+1];
    logic signed [CORDIC_XW-1:0] x_next [CORDIC_N];
    logic signed [CORDIC_XW-1:0] y_next [CORDIC_N];
    logic signed [CORDIC_ZW-1:0] z_next [CORDIC_N];
    logic signed [CORDIC_XW-1:0] xs [CORDIC_N];
    logic signed [CORDIC_XW-1:0] ys [CORDIC_N];
    logic [30:0]                 zprod;
    trig_t                       trig_next;
    trig_t                       trig_reg;

    assign zprod = 31'(turn[13:0]) * 31'(TURN_SCALE);

    always_comb begin
        for (int i = 0; i < CORDIC_N; i++) begin
            xs[i] = x_reg[i] >>> i;
            ys[i] = y_reg[i] >>> i;
            if (!z_reg[i][CORDIC_ZW-1]) begin
                x_next[i] = x_reg[i] - ys[i];
                y_next[i] = y_reg[i] + xs[i];
                z_next[i] = z_reg[i] - CORDIC_ATAN[i];
            end else begin
                x_next[i] = x_reg[i] + ys[i];
                y_next[i] = y_reg[i] - xs[i];
                z_next[i] = z_reg[i] + CORDIC_ATAN[i];
            end
        end
    end

    always_comb begin
        case (q_reg[CORDIC_N])
            QUAD_0: begin
                trig_next.c_val = x_reg[CORDIC_N];
                trig_next.s_val = y_reg[CORDIC_N];
            end
            QUAD_1: begin
                trig_next.c_val = -y_reg[CORDIC_N];
                trig_next.s_val = x_reg[CORDIC_N];
            end
            QUAD_2: begin
                trig_next.c_val = -x_reg[CORDIC_N];
                trig_next.s_val = -y_reg[CORDIC_N];
            end
            default: begin
                trig_next.c_val = y_reg[CORDIC_N];
                trig_next.s_val = -x_reg[CORDIC_N];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({2'b00, zprod[30:14]});
            q_reg[0] <= turn[15:14];
            for (int i = 0; i < CORDIC_N; i++) begin
                x_reg[i+1] <= x_next[i];
                y_reg[i+1] <= y_next[i];
                z_reg[i+1] <= z_next[i];
                q_reg[i+1] <= q_reg[i];
            end
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule
`default_nettype wire

### src/gmh_div.sv
`default_nettype none
module gmh_div (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [gmh_pkg::DIV_NW-1:0]    num,
    input  wire logic [gmh_pkg::DIV_DW-1:0]    den,
    output logic      [gmh_pkg::DIV_QW-1:0]    quo,
    output logic                               ovf
);
    import gmh_pkg::*;

    localparam int LOW_N = DIV_QW - DIV_SHIFT;

    logic [DIV_DW-1:0] rem_reg [DIV_QW+1];
    logic [DIV_QW-1:0] low_reg [DIV_QW+1];
    logic [DIV_QW-1:0] q_reg   [DIV_QW+1];
    logic              ovf_reg [DIV_QW+1];
    logic [DIV_DW:0]   trial   [DIV_QW];
    logic              ge      [DIV_QW];
    logic [DIV_DW-1:0] rem0;

    assign rem0 = DIV_DW'(num[DIV_NW-1:LOW_N]);

    always_comb begin
        for (int j = 0; j < DIV_QW; j++) begin
            trial[j] = {rem_reg[j], low_reg[j][DIV_QW-1]};
            ge[j]    = trial[j] >= {1'b0, den};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem0;
            low_reg[0] <= {num[LOW_N-1:0], {DIV_SHIFT{1'b0}}};
            q_reg[0]   <= '0;
            ovf_reg[0] <= rem0 >= den;
            for (int j = 0; j < DIV_QW; j++) begin
                rem_reg[j+1] <= ge[j] ? DIV_DW'(trial[j] - {1'b0, den})
                                      : DIV_DW'(trial[j]);
                low_reg[j+1] <= {low_reg[j][DIV_QW-2:0], 1'b0};
                q_reg[j+1]   <= {q_reg[j][DIV_QW-2:0], ge[j]};
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign quo = q_reg[DIV_QW];
    assign ovf = ovf_reg[DIV_QW];

endmodule
`default_nettype wire

### src/gmh_exp.sv
`default_nettype none
module gmh_exp (
    input  wire logic [gmh_pkg::EXP_AW-1:0] a,
    input  wire logic                       aclk,
    input  wire logic                       en,
    output logic      [gmh_pkg::EXP_EW-1:0] env
);
    import gmh_pkg::*;

    localparam logic [16:0] LOG2E = 17'd94548;
    localparam logic [15:0] LN2   = 16'd45426;
    localparam logic [EXP_EW-1:0] ONE = 17'd65536;
    // ceil(2^24 / k) for k = 6 down to 1
    localparam logic [24:0] RECIP [EXP_ORDER] = '{
        25'd2796203, 25'd3355444, 25'd4194304, 25'd5592406, 25'd8388608, 25'd16777216
    };

    typedef struct packed {
        logic [15:0] g;
        logic [4:0]  n;
        logic        zero;
    } exp_side_t;

    logic [EXP_AW-1:0] a_reg;
    logic              zero0_reg;
    logic [15:0]       f1_reg;
    logic [4:0]        n1_reg;
    logic              zero1_reg;
    logic [36:0]       tprod;
    logic [31:0]       gprod;
    exp_side_t         se_reg [EXP_ORDER+1];
    logic [EXP_EW-1:0] e_reg  [EXP_ORDER+1];
    exp_side_t         sp_reg [EXP_ORDER];
    logic [32:0]       p_reg  [EXP_ORDER];
    logic [41:0]       qm     [EXP_ORDER];
    logic [EXP_EW-1:0] env_reg;

    assign tprod = 37'(a_reg[19:0]) * 37'(LOG2E);
    assign gprod = 32'(f1_reg) * 32'(LN2);

    always_comb begin
        for (int j = 0; j < EXP_ORDER; j++) begin
            qm[j] = 42'(p_reg[j][32:16]) * 42'(RECIP[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg     <= a;
            zero0_reg <= |a[EXP_AW-1:20];
            n1_reg    <= tprod[36:32];
            f1_reg    <= tprod[31:16];
            zero1_reg <= zero0_reg;
            se_reg[0] <= '{g: gprod[31:16], n: n1_reg, zero: zero1_reg};
            e_reg[0]  <= ONE;
            for (int j = 0; j < EXP_ORDER; j++) begin
                p_reg[j]    <= 33'(se_reg[j].g) * 33'(e_reg[j]);
                sp_reg[j]   <= se_reg[j];
                e_reg[j+1]  <= ONE - qm[j][40:24];
                se_reg[j+1] <= sp_reg[j];
            end
            env_reg <= se_reg[EXP_ORDER].zero ? '0 : e_reg[EXP_ORDER] >> se_reg[EXP_ORDER].n;
        end
    end

    assign env = env_reg;

endmodule
`default_nettype wire
